// File: sv/afem_pkg.sv
// Shared types, constants and helpers for the axis following-error monitor.
package afem_pkg;

  localparam int unsigned MaxAxes   = 4;
  localparam int unsigned AxisW     = 2;
  localparam int unsigned DataW     = 32;
  localparam int unsigned ThreshW   = 31;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned QuotW     = 31;
  localparam int unsigned MagW      = 32;
  localparam int unsigned UmW       = 10;
  localparam int unsigned ProdW     = MagW + UmW;
  // Low bits of the scaled dividend that stay below the quotient window
  localparam int unsigned FracW     = 16;
  localparam int unsigned SplitW    = QuotW - FracW;

  localparam logic [UmW-1:0]     UmPerMm      = UmW'(1000);
  localparam logic [QuotW-1:0]   ErrLimit     = {QuotW{1'b1}};
  localparam logic [ThreshW-1:0] ThreshReset  = ThreshW'(100000);
  localparam logic [DataW-1:0]   TimeoutReset = DataW'(2000);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FEEDBACK_ENABLE = 3'd0,
    CFG_ERROR_THRESHOLD = 3'd1,
    CFG_SILENCE_TIMEOUT = 3'd2,
    CFG_SCALE_AXIS0     = 3'd3,
    CFG_SCALE_AXIS1     = 3'd4,
    CFG_SCALE_AXIS2     = 3'd5,
    CFG_SCALE_AXIS3     = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_UPD
  } afem_state_e;

  // Request into the shared divider
  typedef struct packed {
    logic             start;
    logic [DataW-1:0] rem;
    logic [QuotW-1:0] low;
    logic [DataW-1:0] divisor;
  } div_req_t;

  // Response from the shared divider
  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quot;
  } div_rsp_t;

  // Magnitude of a signed word (never sees the most negative value here)
  function automatic logic [DataW-1:0] abs32(input logic [DataW-1:0] v);
    abs32 = v[DataW-1] ? (~v + DataW'(1)) : v;
  endfunction

endpackage

// File: sv/afem_div.sv
// Restoring divider, one quotient bit per cycle, shared by all axes.
module afem_div import afem_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(QuotW);
  localparam logic [CntW-1:0] LastStep = CntW'(QuotW - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [QuotW-1:0] low_q, low_d;
  logic [QuotW-1:0] quot_q, quot_d;
  logic [DataW-1:0] div_q, div_d;
  logic [DataW:0]   trial;
  logic [DataW:0]   diff;
  logic             ge;

  // One trial subtract per cycle
  assign trial = {rem_q, low_q[QuotW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    quot_d = quot_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.rem;
      low_d  = req_i.low;
      div_d  = req_i.divisor;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? diff[DataW-1:0] : trial[DataW-1:0];
      low_d  = {low_q[QuotW-2:0], 1'b0};
      quot_d = {quot_q[QuotW-2:0], ge};
      cnt_d  = cnt_q + CntW'(1);
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    low_q  <= low_d;
    quot_q <= quot_d;
    div_q  <= div_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// File: sv/axis_following_error_monitor_unit.sv
// Top level: per-axis following-error monitor with drift and silence alarms.
// Each beat carries one sample (or a clear request) for one axis and yields
// one result beat. A sample that needs a unit conversion runs, from
// acceptance until the block is ready again, through the operand difference,
// the constant multiply by 1000, a range check, the shared
// one-bit-per-cycle restoring divider, whose quotient is taken on its done
// pulse, and the state update. Clear requests, stale or disabled samples and
// beats for an absent axis skip the conversion; zero-scale and saturated
// conversions skip the divider. The next beat is taken while the previous
// result still waits in the output register; the update of the following
// beat holds until that result is taken. Configuration takes effect on
// the cycle after the write.
module axis_following_error_monitor_unit import afem_pkg::*; #(
  parameter int unsigned NUM_AXES = MaxAxes
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_wdata_i,
  // input beats
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [AxisW-1:0]   axis_i,
  input  logic               stale_i,
  input  logic               moving_i,
  input  logic [DataW-1:0]   encoder_position_i,
  input  logic [DataW-1:0]   target_position_i,
  input  logic [DataW-1:0]   commanded_position_i,
  input  logic [DataW-1:0]   now_ms_i,
  // result beats
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               sample_valid_o,
  output logic [DataW-1:0]   position_error_um_o,
  output logic [DataW-1:0]   peak_error_um_o,
  output logic               drift_active_o,
  output logic [DataW-1:0]   drift_count_o,
  output logic [DataW-1:0]   drift_duration_ms_o,
  output logic               drift_raised_o,
  output logic               silence_raised_o,
  output logic               watchdog_alarm_o
);

  localparam int unsigned AxW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam logic [AxisW:0] NumAxesL = (AxisW + 1)'(NUM_AXES);

  // ---------------------------------------------------------------- config
  logic               fb_en_q;
  logic [ThreshW-1:0] thresh_q;
  logic [DataW-1:0]   timeout_q;
  logic [DataW-1:0]   scale_q [MaxAxes];
  logic [AxisW-1:0]   cfg_scale_idx;

  assign cfg_scale_idx = AxisW'(cfg_index_i - CFG_SCALE_AXIS0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_en_q   <= 1'b0;
      thresh_q  <= ThreshReset;
      timeout_q <= TimeoutReset;
      for (int i = 0; i < MaxAxes; i++) begin
        scale_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FEEDBACK_ENABLE: fb_en_q   <= cfg_wdata_i[0];
        CFG_ERROR_THRESHOLD: thresh_q  <= cfg_wdata_i[ThreshW-1:0];
        CFG_SILENCE_TIMEOUT: timeout_q <= cfg_wdata_i;
        CFG_SCALE_AXIS0, CFG_SCALE_AXIS1, CFG_SCALE_AXIS2, CFG_SCALE_AXIS3:
          scale_q[cfg_scale_idx] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- captured beat
  op_e              op_q;
  logic [AxisW-1:0] axis_q;
  logic             stale_q, moving_q;
  logic [DataW-1:0] enc_q, tgt_q, cmd_q, now_q;
  logic             in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q     <= op_e'(operation_i);
      axis_q   <= axis_i;
      stale_q  <= stale_i;
      moving_q <= moving_i;
      enc_q    <= encoder_position_i;
      tgt_q    <= target_position_i;
      cmd_q    <= commanded_position_i;
      now_q    <= now_ms_i;
    end
  end

  logic             axis_ok;
  logic [AxW-1:0]   aidx;
  logic             need_conv;
  logic [DataW-1:0] scale_sel;

  assign axis_ok   = {1'b0, axis_q} < NumAxesL;
  assign aidx      = axis_q[AxW-1:0];
  assign need_conv = axis_ok && (op_q == OP_SAMPLE) && fb_en_q && !stale_q;
  assign scale_sel = scale_q[axis_q];

  // ---------------------------------------------------------- conversion path
  logic [DataW:0]   diff_w;
  logic [DataW:0]   diff_abs;
  logic             neg_q;
  logic [MagW-1:0]  mag_q;
  logic [ProdW-1:0] prod_q;
  logic             ovf;
  logic [DataW-1:0] err_q, err_d;
  logic             err_load;
  logic [QuotW-1:0] quot_sel;

  // Exact 33-bit difference against the reference for the motion state
  assign diff_w   = {enc_q[DataW-1], enc_q}
                  - (moving_q ? {cmd_q[DataW-1], cmd_q} : {tgt_q[DataW-1], tgt_q});
  assign diff_abs = diff_w[DataW] ? (~diff_w + (DataW + 1)'(1)) : diff_w;

  // Quotient would reach 2^31: mag*1000*2^16 >= scale*2^31
  assign ovf = {5'b0, prod_q} >= {scale_sel, 15'b0};

  div_req_t div_req;
  div_rsp_t div_rsp;

  afem_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------- sequencer
  afem_state_e state_q, state_d;
  logic        out_valid_q;
  logic        upd_fire;

  assign upd_fire = (state_q == ST_UPD) && (!out_valid_q || out_ready_i);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_DIFF;
      ST_DIFF: state_d = need_conv ? ST_MUL : ST_UPD;
      ST_MUL:  state_d = ST_CHK;
      ST_CHK:  state_d = ((scale_sel == '0) || ovf) ? ST_UPD : ST_DIV;
      ST_DIV:  if (div_rsp.done) state_d = ST_UPD;
      ST_UPD:  if (upd_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_o      = 1'b0;
    div_req.start   = 1'b0;
    div_req.rem     = DataW'(prod_q[ProdW-1:SplitW]);
    div_req.low     = {prod_q[SplitW-1:0], FracW'(0)};
    div_req.divisor = scale_sel;
    err_load        = 1'b0;
    quot_sel        = div_rsp.quot;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_CHK: begin
        if (scale_sel == '0) begin
          err_load = 1'b1;
          quot_sel = '0;
        end else if (ovf) begin
          err_load = 1'b1;
          quot_sel = ErrLimit;
        end else begin
          div_req.start = 1'b1;
        end
      end
      ST_DIV: err_load = div_rsp.done;
      default: ;
    endcase
  end

  // Apply the sign to the unsigned quotient
  assign err_d = neg_q ? (~{1'b0, quot_sel} + DataW'(1)) : {1'b0, quot_sel};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIFF) begin
      neg_q <= diff_w[DataW];
      mag_q <= diff_abs[MagW-1:0];
    end
    if (state_q == ST_MUL) begin
      prod_q <= mag_q * UmPerMm;
    end
    if (err_load) begin
      err_q <= err_d;
    end
  end

  // ---------------------------------------------------------- per-axis record
  logic [DataW-1:0] cur_err_q   [NUM_AXES];
  logic [DataW-1:0] peak_q      [NUM_AXES];
  logic             drift_q     [NUM_AXES];
  logic [DataW-1:0] onsets_q    [NUM_AXES];
  logic [DataW-1:0] start_q     [NUM_AXES];
  logic [DataW-1:0] last_enc_q  [NUM_AXES];
  logic [DataW-1:0] last_chg_q  [NUM_AXES];
  logic             silence_q   [NUM_AXES];

  logic [DataW-1:0] nx_cur, nx_peak, nx_onsets, nx_start, nx_last_enc, nx_last_chg;
  logic             nx_drift, nx_silence;
  logic             r_valid, r_draise, r_sraise;
  logic             silence_due;
  logic [DataW-1:0] err_mag;

  assign silence_due = (now_q - last_chg_q[aidx]) > timeout_q;
  assign err_mag     = abs32(err_q);

  // Record update for the addressed axis
  always_comb begin
    nx_cur      = cur_err_q[aidx];
    nx_peak     = peak_q[aidx];
    nx_drift    = drift_q[aidx];
    nx_onsets   = onsets_q[aidx];
    nx_start    = start_q[aidx];
    nx_last_enc = last_enc_q[aidx];
    nx_last_chg = last_chg_q[aidx];
    nx_silence  = silence_q[aidx];
    r_valid     = 1'b1;
    r_draise    = 1'b0;
    r_sraise    = 1'b0;
    if (op_q == OP_CLEAR) begin
      nx_cur   = '0;
      nx_peak  = '0;
      nx_drift = 1'b0;
      nx_start = '0;
    end else if (fb_en_q) begin
      if (stale_q) begin
        r_valid = 1'b0;
        if (moving_q && silence_due && !silence_q[aidx]) begin
          nx_silence = 1'b1;
          r_sraise   = 1'b1;
        end
      end else begin
        nx_cur = err_q;
        if (err_mag > abs32(peak_q[aidx])) nx_peak = err_q;
        // drift alarm against the threshold
        if (err_mag > {1'b0, thresh_q}) begin
          if (!drift_q[aidx]) begin
            nx_drift  = 1'b1;
            nx_start  = now_q;
            nx_onsets = onsets_q[aidx] + DataW'(1);
            r_draise  = 1'b1;
          end
        end else if (drift_q[aidx]) begin
          nx_drift = 1'b0;
          nx_start = '0;
        end
        // encoder silence watchdog
        if (moving_q && (enc_q == last_enc_q[aidx])) begin
          if (silence_due && !silence_q[aidx]) begin
            nx_silence = 1'b1;
            r_sraise   = 1'b1;
          end
        end else begin
          nx_last_enc = enc_q;
          nx_last_chg = now_q;
          nx_silence  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        cur_err_q[i]  <= '0;
        peak_q[i]     <= '0;
        drift_q[i]    <= 1'b0;
        onsets_q[i]   <= '0;
        start_q[i]    <= '0;
        last_enc_q[i] <= '0;
        last_chg_q[i] <= '0;
        silence_q[i]  <= 1'b0;
      end
    end else if (upd_fire && axis_ok) begin
      cur_err_q[aidx]  <= nx_cur;
      peak_q[aidx]     <= nx_peak;
      drift_q[aidx]    <= nx_drift;
      onsets_q[aidx]   <= nx_onsets;
      start_q[aidx]    <= nx_start;
      last_enc_q[aidx] <= nx_last_enc;
      last_chg_q[aidx] <= nx_last_chg;
      silence_q[aidx]  <= nx_silence;
    end
  end

  // ---------------------------------------------------------- result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      if (axis_ok) begin
        sample_valid_o      <= r_valid;
        position_error_um_o <= nx_cur;
        peak_error_um_o     <= nx_peak;
        drift_active_o      <= nx_drift;
        drift_count_o       <= nx_onsets;
        drift_duration_ms_o <= nx_drift ? (now_q - nx_start) : '0;
        drift_raised_o      <= r_draise;
        silence_raised_o    <= r_sraise;
        watchdog_alarm_o    <= nx_silence;
      end else begin
        sample_valid_o      <= 1'b1;
        position_error_um_o <= '0;
        peak_error_um_o     <= '0;
        drift_active_o      <= 1'b0;
        drift_count_o       <= '0;
        drift_duration_ms_o <= '0;
        drift_raised_o      <= 1'b0;
        silence_raised_o    <= 1'b0;
        watchdog_alarm_o    <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
